>>> hdl/stsel_pkg.sv
// Shared types, codes and constants for the symbiosis transfer selector.
// Used by every module in this folder; depends on nothing.
package stsel_pkg;

   localparam int NUM_TASKS_DEF  = 8;
   localparam int COUNT_BITS_DEF = 32;
   localparam int TASK_BITS      = 3;
   localparam int RANK_BITS      = 10;
   localparam int N_BITS         = 10;
   localparam int RATIO_BITS     = 16;
   localparam int NUM_OUTCOMES   = 6;
   localparam logic [N_BITS-1:0] OFFSPRING_RESET = 10'd100;

   typedef enum logic {
      OP_RECORD = 1'b0,
      OP_SELECT = 1'b1
   } op_type;

   // Values of the six counting outcomes double as field positions in a counter entry.
   typedef enum logic [2:0] {
      OC_BOTH_GOOD    = 3'd0,
      OC_GOOD_NEUTRAL = 3'd1,
      OC_GOOD_HARM    = 3'd2,
      OC_BOTH_NEUTRAL = 3'd3,
      OC_NEUTRAL_HARM = 3'd4,
      OC_BOTH_HARM    = 3'd5,
      OC_NONE         = 3'd6
   } outcome_type;

   typedef enum logic [1:0] {
      CMD_NULL   = 2'd0,
      CMD_RECORD = 2'd1,
      CMD_SELECT = 2'd2
   } cmd_kind_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_SUM,
      ST_DIV,
      ST_PICK,
      ST_MUL,
      ST_TDIV,
      ST_DONE
   } back_state_type;

   typedef struct packed {
      logic                 operation;
      logic [TASK_BITS-1:0] task_a;
      logic [TASK_BITS-1:0] task_b;
      logic [RANK_BITS-1:0] rank_own;
      logic [RANK_BITS-1:0] rank_other;
   } req_type;

   typedef struct packed {
      logic                  undefined_outcome;
      logic [TASK_BITS-1:0]  best_partner;
      logic [RATIO_BITS-1:0] best_ratio;
      logic [N_BITS-1:0]     transfer_count;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type         kind;
      outcome_type          outcome;
      logic [TASK_BITS-1:0] task_a;
      logic [TASK_BITS-1:0] task_b;
      logic [N_BITS-1:0]    n;
   } cmd_type;

endpackage

>>> hdl/stsel_front.sv
// Front end: classifies an incoming transfer into a back-end command.
// Depends on stsel_pkg.
module stsel_front #(
   parameter int NUM_TASKS = stsel_pkg::NUM_TASKS_DEF
) (
   input  stsel_pkg::req_type           req,
   input  logic [stsel_pkg::N_BITS-1:0] n,
   output stsel_pkg::cmd_type           cmd
);

   localparam int CMP_W = 7;

   logic bad_a;
   logic bad_b;
   logic [stsel_pkg::RANK_BITS+1:0] own_x4;
   logic [stsel_pkg::RANK_BITS+1:0] own_x2;
   logic [stsel_pkg::RANK_BITS+1:0] oth_x4;
   logic [stsel_pkg::RANK_BITS+1:0] oth_x2;
   logic [stsel_pkg::RANK_BITS+1:0] n_ext;
   logic og;
   logic oh;
   logic sg;
   logic sh;

   assign bad_a  = CMP_W'(req.task_a) >= CMP_W'(NUM_TASKS);
   assign bad_b  = CMP_W'(req.task_b) >= CMP_W'(NUM_TASKS);
   assign own_x4 = {req.rank_own, 2'b00};
   assign own_x2 = {1'b0, req.rank_own, 1'b0};
   assign oth_x4 = {req.rank_other, 2'b00};
   assign oth_x2 = {1'b0, req.rank_other, 1'b0};
   assign n_ext  = {2'b00, n};
   assign og     = own_x4 <= n_ext;
   assign oh     = own_x2 <= n_ext;
   assign sg     = oth_x4 <= n_ext;
   assign sh     = oth_x2 <= n_ext;

   always_comb begin
      cmd.task_a  = req.task_a;
      cmd.task_b  = req.task_b;
      cmd.n       = n;
      cmd.outcome = stsel_pkg::OC_NONE;
      priority if (og && sg) cmd.outcome = stsel_pkg::OC_BOTH_GOOD;
      else if (og && sh)     cmd.outcome = stsel_pkg::OC_GOOD_NEUTRAL;
      else if (og)           cmd.outcome = stsel_pkg::OC_GOOD_HARM;
      else if (oh && sh)     cmd.outcome = stsel_pkg::OC_BOTH_NEUTRAL;
      else if (oh)           cmd.outcome = stsel_pkg::OC_NEUTRAL_HARM;
      else if (!sh)          cmd.outcome = stsel_pkg::OC_BOTH_HARM;
      else                   cmd.outcome = stsel_pkg::OC_NONE;
      // Drop items naming a task beyond the configured count; a select checks only task_a.
      if (req.operation == stsel_pkg::OP_SELECT) begin
         cmd.kind = bad_a ? stsel_pkg::CMD_NULL : stsel_pkg::CMD_SELECT;
      end else begin
         cmd.kind = (bad_a || bad_b) ? stsel_pkg::CMD_NULL : stsel_pkg::CMD_RECORD;
      end
   end

endmodule

>>> hdl/stsel_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on stsel_pkg.
module stsel_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  stsel_pkg::cmd_type push_cmd,
   input  logic               pop,
   output logic               full,
   output logic               valid,
   output stsel_pkg::cmd_type head
);

   stsel_pkg::cmd_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full  = count_ff == 2'd2;
   assign valid = count_ff != 2'd0;
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef NO_ASSERTIONS
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != 2'd0)
      else $error("queue popped while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count did not advance on push");
`endif

endmodule

>>> hdl/stsel_back.sv
// Back end: counter memory, clearing pass, record update and partner search
// with bit-serial ratio and transfer-count division. Depends on stsel_pkg.
module stsel_back #(
   parameter int NUM_TASKS  = stsel_pkg::NUM_TASKS_DEF,
   parameter int COUNT_BITS = stsel_pkg::COUNT_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  stsel_pkg::cmd_type cmd,
   output logic               cmd_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output stsel_pkg::rsp_type rsp_data
);

   localparam int DEPTH  = NUM_TASKS * NUM_TASKS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int TASK_W = $clog2(NUM_TASKS);
   localparam int CMP_W  = (TASK_W > stsel_pkg::TASK_BITS) ? TASK_W : stsel_pkg::TASK_BITS;
   localparam int POS_W  = COUNT_BITS + 2;
   localparam int TOT_W  = COUNT_BITS + 3;
   localparam int PROD_W = COUNT_BITS + 12;
   localparam int NB     = stsel_pkg::N_BITS;
   localparam int RB     = stsel_pkg::RATIO_BITS;
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);
   localparam logic [ADDR_W-1:0] ROW_SIZE  = ADDR_W'(NUM_TASKS);
   localparam logic [TASK_W-1:0] TASK_LAST = TASK_W'(NUM_TASKS - 1);
   localparam logic [3:0] DIV_LAST = 4'(RB - 1);
   localparam logic [3:0] N_LAST   = 4'(NB - 1);

   typedef logic [stsel_pkg::NUM_OUTCOMES-1:0][COUNT_BITS-1:0] entry_type;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;
   entry_type wr_data;
   entry_type ones_entry;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] rec_addr;
   logic [ADDR_W-1:0] sel_addr;

   stsel_pkg::back_state_type state_ff, state_in;
   stsel_pkg::cmd_type        cmd_ff, cmd_in;
   stsel_pkg::rsp_type        res_ff, res_in;
   stsel_pkg::rsp_type        rsp_data_ff, rsp_data_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [TASK_W-1:0] t_ff, t_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W-1:0]  rest_ff, rest_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [TOT_W-1:0]  rem_ff, rem_in;
   logic [RB-1:0]     q_ff, q_in;
   logic [3:0]        step_ff, step_in;
   logic              found_ff, found_in;
   logic [TASK_W-1:0] best_ff, best_in;
   logic [RB-1:0]     best_r_ff, best_r_in;
   logic [POS_W-1:0]  best_pos_ff, best_pos_in;
   logic [TOT_W-1:0]  best_total_ff, best_total_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [PROD_W-1:0] mcand_ff, mcand_in;
   logic [NB-1:0]     mplier_ff, mplier_in;
   logic [PROD_W-1:0] dsr_ff, dsr_in;
   logic [NB-1:0]     qt_ff, qt_in;
   logic [TOT_W:0]    rem2;
   logic [TOT_W:0]    tot_ext;
   logic              out_free;
   logic              is_self;

   assign rec_addr = ADDR_W'(cmd_ff.task_a) * ROW_SIZE + ADDR_W'(cmd_ff.task_b);
   assign sel_addr = ADDR_W'(cmd_ff.task_a) * ROW_SIZE + ADDR_W'(t_ff);
   assign rd_addr  = (cmd_ff.kind == stsel_pkg::CMD_SELECT) ? sel_addr : rec_addr;
   assign rem2     = {rem_ff, 1'b0};
   assign tot_ext  = {1'b0, total_ff};
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign is_self  = CMP_W'(t_ff) == CMP_W'(cmd_ff.task_a);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      for (int i = 0; i < stsel_pkg::NUM_OUTCOMES; i++) begin
         ones_entry[i] = COUNT_BITS'(1);
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      res_in        = res_ff;
      clr_in        = clr_ff;
      t_in          = t_ff;
      pos_in        = pos_ff;
      rest_in       = rest_ff;
      total_in      = total_ff;
      rem_in        = rem_ff;
      q_in          = q_ff;
      step_in       = step_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      best_r_in     = best_r_ff;
      best_pos_in   = best_pos_ff;
      best_total_in = best_total_ff;
      prod_in       = prod_ff;
      mcand_in      = mcand_ff;
      mplier_in     = mplier_ff;
      dsr_in        = dsr_ff;
      qt_in         = qt_ff;
      cmd_pop       = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = rec_addr;
      wr_data       = rd_data_ff;
      rsp_valid_in  = rsp_stall ? rsp_valid_ff : 1'b0;
      rsp_data_in   = rsp_data_ff;

      unique case (state_ff)
         stsel_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = ones_entry;
            clr_in  = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_LAST) begin
               state_in = stsel_pkg::ST_IDLE;
            end
         end
         stsel_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd;
               res_in   = '0;
               t_in     = '0;
               found_in = 1'b0;
               unique case (cmd.kind)
                  stsel_pkg::CMD_SELECT: state_in = stsel_pkg::ST_READ;
                  stsel_pkg::CMD_RECORD: begin
                     if (cmd.outcome == stsel_pkg::OC_NONE) begin
                        res_in.undefined_outcome = 1'b1;
                        state_in = stsel_pkg::ST_DONE;
                     end else begin
                        state_in = stsel_pkg::ST_READ;
                     end
                  end
                  default: state_in = stsel_pkg::ST_DONE;
               endcase
            end
         end
         stsel_pkg::ST_READ: begin
            // Skip the asking task's own pair.
            if (cmd_ff.kind == stsel_pkg::CMD_SELECT && is_self) begin
               if (t_ff == TASK_LAST) begin
                  state_in  = stsel_pkg::ST_MUL;
                  prod_in   = '0;
                  mcand_in  = PROD_W'(best_pos_ff);
                  mplier_in = cmd_ff.n;
                  step_in   = '0;
               end else begin
                  t_in = t_ff + TASK_W'(1);
               end
            end else begin
               state_in = stsel_pkg::ST_LOAD;
            end
         end
         stsel_pkg::ST_LOAD: begin
            if (cmd_ff.kind == stsel_pkg::CMD_RECORD) begin
               wr_en = 1'b1;
               for (int i = 0; i < stsel_pkg::NUM_OUTCOMES; i++) begin
                  if (3'(i) == cmd_ff.outcome && rd_data_ff[i] != '1) begin
                     wr_data[i] = rd_data_ff[i] + COUNT_BITS'(1);
                  end
               end
               state_in = stsel_pkg::ST_DONE;
            end else begin
               pos_in = POS_W'(rd_data_ff[stsel_pkg::OC_BOTH_GOOD])
                      + POS_W'(rd_data_ff[stsel_pkg::OC_GOOD_NEUTRAL])
                      + POS_W'(rd_data_ff[stsel_pkg::OC_GOOD_HARM]);
               rest_in = POS_W'(rd_data_ff[stsel_pkg::OC_BOTH_NEUTRAL])
                       + POS_W'(rd_data_ff[stsel_pkg::OC_NEUTRAL_HARM])
                       + POS_W'(rd_data_ff[stsel_pkg::OC_BOTH_HARM]);
               state_in = stsel_pkg::ST_SUM;
            end
         end
         stsel_pkg::ST_SUM: begin
            total_in = TOT_W'(pos_ff) + TOT_W'(rest_ff);
            rem_in   = TOT_W'(pos_ff);
            q_in     = '0;
            step_in  = '0;
            state_in = stsel_pkg::ST_DIV;
         end
         stsel_pkg::ST_DIV: begin
            // One quotient bit per cycle of pos * 2^16 / total.
            if (rem2 >= tot_ext) begin
               rem_in = TOT_W'(rem2 - tot_ext);
               q_in   = {q_ff[RB-2:0], 1'b1};
            end else begin
               rem_in = TOT_W'(rem2);
               q_in   = {q_ff[RB-2:0], 1'b0};
            end
            step_in = step_ff + 4'd1;
            if (step_ff == DIV_LAST) begin
               state_in = stsel_pkg::ST_PICK;
            end
         end
         stsel_pkg::ST_PICK: begin
            if (!found_ff || q_ff > best_r_ff) begin
               found_in      = 1'b1;
               best_in       = t_ff;
               best_r_in     = q_ff;
               best_pos_in   = pos_ff;
               best_total_in = total_ff;
            end
            if (t_ff == TASK_LAST) begin
               state_in  = stsel_pkg::ST_MUL;
               prod_in   = '0;
               mcand_in  = (!found_ff || q_ff > best_r_ff) ? PROD_W'(pos_ff)
                                                           : PROD_W'(best_pos_ff);
               mplier_in = cmd_ff.n;
               step_in   = '0;
            end else begin
               t_in     = t_ff + TASK_W'(1);
               state_in = stsel_pkg::ST_READ;
            end
         end
         stsel_pkg::ST_MUL: begin
            if (mplier_ff[0]) begin
               prod_in = prod_ff + mcand_ff;
            end
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            step_in   = step_ff + 4'd1;
            if (step_ff == N_LAST) begin
               state_in = stsel_pkg::ST_TDIV;
               dsr_in   = PROD_W'(best_total_ff) << (NB - 1);
               qt_in    = '0;
               step_in  = '0;
            end
         end
         stsel_pkg::ST_TDIV: begin
            if (prod_ff >= dsr_ff) begin
               prod_in = prod_ff - dsr_ff;
               qt_in   = {qt_ff[NB-2:0], 1'b1};
            end else begin
               qt_in   = {qt_ff[NB-2:0], 1'b0};
            end
            dsr_in  = dsr_ff >> 1;
            step_in = step_ff + 4'd1;
            if (step_ff == N_LAST) begin
               res_in.best_partner   = stsel_pkg::TASK_BITS'(best_ff);
               res_in.best_ratio     = best_r_ff;
               res_in.transfer_count = qt_in;
               state_in = stsel_pkg::ST_DONE;
            end
         end
         stsel_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = stsel_pkg::ST_IDLE;
            end
         end
         default: state_in = stsel_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stsel_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      res_ff        <= res_in;
      rsp_data_ff   <= rsp_data_in;
      t_ff          <= t_in;
      pos_ff        <= pos_in;
      rest_ff       <= rest_in;
      total_ff      <= total_in;
      rem_ff        <= rem_in;
      q_ff          <= q_in;
      step_ff       <= step_in;
      found_ff      <= found_in;
      best_ff       <= best_in;
      best_r_ff     <= best_r_in;
      best_pos_ff   <= best_pos_in;
      best_total_ff <= best_total_in;
      prod_ff       <= prod_in;
      mcand_ff      <= mcand_in;
      mplier_ff     <= mplier_in;
      dsr_ff        <= dsr_in;
      qt_ff         <= qt_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

`ifndef NO_ASSERTIONS
   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == stsel_pkg::ST_CLEAR |-> !cmd_pop)
      else $error("command taken during clearing pass");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == stsel_pkg::ST_DIV |-> rem_ff < total_ff)
      else $error("ratio remainder not below total");
   a_best_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == stsel_pkg::ST_MUL |-> best_total_ff > TOT_W'(best_pos_ff))
      else $error("best total not above positive count");
   a_write_owner: assert property (@(posedge clock) disable iff (reset)
      (wr_en && state_ff != stsel_pkg::ST_CLEAR) |->
         (state_ff == stsel_pkg::ST_LOAD && cmd_ff.kind == stsel_pkg::CMD_RECORD))
      else $error("counter write outside record update");
`endif

endmodule

>>> hdl/symbiosis_transfer_selector_unit.sv
// Top level of the symbiosis transfer selector: offspring-count register,
// front end, command queue and back end. Depends on stsel_pkg and submodules.

// After reset the unit sweeps its counter memory, one entry per cycle, before
// it takes the first command; requests are queued meanwhile and the csr port
// is always writable. A record transfer in the back end reads the memory,
// registers the data and writes the updated entry. A select transfer runs the
// one-bit-per-cycle 16-bit ratio divider for each partner task other than the
// asking task, then the bit-serial transfer-count multiply and divide.
// A two-entry queue lets the front end take new requests while the back end
// works and while a finished response waits in the output register.
module symbiosis_transfer_selector_unit #(
   parameter int NUM_TASKS  = stsel_pkg::NUM_TASKS_DEF,
   parameter int COUNT_BITS = stsel_pkg::COUNT_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  stsel_pkg::req_type           req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output stsel_pkg::rsp_type           rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [stsel_pkg::N_BITS-1:0] csr_data
);

   logic [stsel_pkg::N_BITS-1:0] n_ff, n_in;
   stsel_pkg::cmd_type front_cmd;
   stsel_pkg::cmd_type head_cmd;
   logic q_full;
   logic q_valid;
   logic q_pop;
   logic q_push;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;
   assign n_in      = (csr_valid && csr_ready) ? csr_data : n_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff <= stsel_pkg::OFFSPRING_RESET;
      end else begin
         n_ff <= n_in;
      end
   end

   stsel_front #(
      .NUM_TASKS(NUM_TASKS)
   ) u_front (
      .req (req_data),
      .n   (n_ff),
      .cmd (front_cmd)
   );

   stsel_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (front_cmd),
      .pop      (q_pop),
      .full     (q_full),
      .valid    (q_valid),
      .head     (head_cmd)
   );

   stsel_back #(
      .NUM_TASKS  (NUM_TASKS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd       (head_cmd),
      .cmd_pop   (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> verif/tb.sv
// Testbench for symbiosis_transfer_selector_unit: record and select transfers
// checked against a behavioral predictor in a scoreboard class. Needs stsel_pkg.
`timescale 1ns / 1ps

module tb;

   localparam int NT = 8;
   localparam longint CMAX = 64'hFFFF_FFFF;
   localparam int IDLE_LIMIT = 20000;

   class outcome_scoreboard;
      longint unsigned cnt[stsel_pkg::NUM_OUTCOMES][NT*NT];
      logic [stsel_pkg::N_BITS-1:0] n;
      stsel_pkg::rsp_type pending[$];
      int errors;
      int results;

      function void clear();
         for (int k = 0; k < stsel_pkg::NUM_OUTCOMES; k++)
            for (int i = 0; i < NT*NT; i++) cnt[k][i] = 1;
         n = stsel_pkg::OFFSPRING_RESET;
         errors = 0;
         results = 0;
      endfunction

      function void bump(int k, int idx);
         if (cnt[k][idx] < CMAX) cnt[k][idx]++;
      endfunction

      function longint unsigned pos_of(int idx);
         return cnt[stsel_pkg::OC_BOTH_GOOD][idx] + cnt[stsel_pkg::OC_GOOD_NEUTRAL][idx]
                + cnt[stsel_pkg::OC_GOOD_HARM][idx];
      endfunction

      function longint unsigned rest_of(int idx);
         return cnt[stsel_pkg::OC_NEUTRAL_HARM][idx] + cnt[stsel_pkg::OC_BOTH_HARM][idx]
                + cnt[stsel_pkg::OC_BOTH_NEUTRAL][idx];
      endfunction

      function void note_request(stsel_pkg::req_type r);
         stsel_pkg::rsp_type e;
         int idx;
         bit og, oh, sg, sh;
         longint unsigned p, tot, q, bq;
         int best;
         e = '0;
         if (r.operation == stsel_pkg::OP_RECORD) begin
            idx = r.task_a * NT + r.task_b;
            og = 4 * r.rank_own <= n;   oh = 2 * r.rank_own <= n;
            sg = 4 * r.rank_other <= n; sh = 2 * r.rank_other <= n;
            if (og && sg) bump(stsel_pkg::OC_BOTH_GOOD, idx);
            else if (og && sh) bump(stsel_pkg::OC_GOOD_NEUTRAL, idx);
            else if (og) bump(stsel_pkg::OC_GOOD_HARM, idx);
            else if (oh && sh) bump(stsel_pkg::OC_BOTH_NEUTRAL, idx);
            else if (oh) bump(stsel_pkg::OC_NEUTRAL_HARM, idx);
            else if (!sh) bump(stsel_pkg::OC_BOTH_HARM, idx);
            else e.undefined_outcome = 1'b1;
         end else begin
            best = -1; bq = 0;
            for (int t = 0; t < NT; t++) begin
               if (t == r.task_a) continue;
               idx = r.task_a * NT + t;
               p = pos_of(idx);
               tot = p + rest_of(idx);
               q = (p << 16) / tot;
               if (best < 0 || q > bq) begin
                  best = t; bq = q;
               end
            end
            idx = r.task_a * NT + best;
            p = pos_of(idx);
            tot = p + rest_of(idx);
            q = (p * n) / tot;
            e.best_partner = best[stsel_pkg::TASK_BITS-1:0];
            e.best_ratio = bq[stsel_pkg::RATIO_BITS-1:0];
            e.transfer_count = q[stsel_pkg::N_BITS-1:0];
         end
         pending = {pending, e};
      endfunction

      function void check_response(stsel_pkg::rsp_type a);
         stsel_pkg::rsp_type e;
         results++;
         if (pending.size() == 0) begin
            $error("unexpected response %h", a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.undefined_outcome !== e.undefined_outcome) begin
            $error("undefined_outcome exp %0d got %0d", e.undefined_outcome,
                   a.undefined_outcome);
            errors++;
         end
         if (a.best_partner !== e.best_partner) begin
            $error("best_partner exp %0d got %0d", e.best_partner, a.best_partner);
            errors++;
         end
         if (a.best_ratio !== e.best_ratio) begin
            $error("best_ratio exp %0d got %0d", e.best_ratio, a.best_ratio);
            errors++;
         end
         if (a.transfer_count !== e.transfer_count) begin
            $error("transfer_count exp %0d got %0d", e.transfer_count, a.transfer_count);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall;
   stsel_pkg::req_type req_data = '0;
   logic rsp_valid, rsp_stall = 0;
   stsel_pkg::rsp_type rsp_data;
   logic csr_valid = 0, csr_ready;
   logic [stsel_pkg::N_BITS-1:0] csr_data = '0;

   int send_idle = 0, recv_idle = 0;
   int quiet = 0;
   int n_sent = 0;
   outcome_scoreboard sb;

   symbiosis_transfer_selector_unit i_dut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_valid, .csr_ready, .csr_data
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Receiver side: check transfers and randomize the stall.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
         rsp_stall <= ($urandom_range(99) < recv_idle);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet <= 0;
         else quiet <= quiet + 1;
         if (quiet >= IDLE_LIMIT) begin
            $display("symbiosis_transfer_selector_unit: mismatch");
            $finish;
         end
      end
   end

   // Hold valid between back-to-back transfers; drop it only while idling.
   task automatic send(stsel_pkg::req_type r);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(r);
      n_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_count(logic [stsel_pkg::N_BITS-1:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.n = v;
   endtask

   function automatic stsel_pkg::req_type make_req(logic op, int ta, int tb, int ro, int rs);
      stsel_pkg::req_type r;
      r.operation = op;
      r.task_a = ta[stsel_pkg::TASK_BITS-1:0];
      r.task_b = tb[stsel_pkg::TASK_BITS-1:0];
      r.rank_own = ro[stsel_pkg::RANK_BITS-1:0];
      r.rank_other = rs[stsel_pkg::RANK_BITS-1:0];
      return r;
   endfunction

   // Ranks near the quarter and half thresholds of n in half the draws, else random.
   function automatic int pick_rank(int nv);
      case ($urandom_range(3))
         0: return $urandom_range(1023);
         1: return (nv / 4 + $urandom_range(2)) % 1024;
         2: return (nv / 2 + $urandom_range(2)) % 1024;
         default: return $urandom_range(nv);
      endcase
   endfunction

   task automatic random_phase(int count);
      int nv;
      int ta;
      int hot;
      nv = sb.n;
      hot = $urandom_range(NT-1);
      for (int i = 0; i < count; i++) begin
         ta = ($urandom_range(2) == 0) ? hot : $urandom_range(NT-1);
         if ($urandom_range(4) == 0)
            send(make_req(stsel_pkg::OP_SELECT, ta, $urandom_range(NT-1),
                          $urandom_range(1023), $urandom_range(1023)));
         else
            send(make_req(stsel_pkg::OP_RECORD, ta, $urandom_range(NT-1), pick_rank(nv),
                          pick_rank(nv)));
      end
   endtask

   initial begin
      sb = new();
      sb.clear();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      send_idle = 11; recv_idle = 72;
      // Directed: every outcome at n = 100, undefined case, self pair, selects.
      send(make_req(stsel_pkg::OP_RECORD, 0, 1, 0, 0));
      send(make_req(stsel_pkg::OP_RECORD, 0, 1, 25, 50));
      send(make_req(stsel_pkg::OP_RECORD, 0, 2, 25, 51));
      send(make_req(stsel_pkg::OP_RECORD, 0, 3, 50, 50));
      send(make_req(stsel_pkg::OP_RECORD, 0, 4, 26, 1023));
      send(make_req(stsel_pkg::OP_RECORD, 7, 7, 1023, 1023));
      send(make_req(stsel_pkg::OP_RECORD, 7, 6, 51, 0));
      send(make_req(stsel_pkg::OP_RECORD, 3, 3, 0, 0));
      send(make_req(stsel_pkg::OP_SELECT, 0, 7, 1023, 1023));
      send(make_req(stsel_pkg::OP_SELECT, 7, 0, 0, 0));
      send(make_req(stsel_pkg::OP_SELECT, 3, 3, 0, 0));
      drain();
      write_count(10'd1);
      send(make_req(stsel_pkg::OP_RECORD, 1, 2, 0, 1));
      send(make_req(stsel_pkg::OP_RECORD, 1, 2, 1, 1));
      send(make_req(stsel_pkg::OP_SELECT, 1, 0, 0, 0));
      drain();
      write_count(10'd1023);
      send(make_req(stsel_pkg::OP_RECORD, 2, 5, 255, 511));
      send(make_req(stsel_pkg::OP_RECORD, 2, 5, 256, 512));
      send(make_req(stsel_pkg::OP_SELECT, 2, 0, 0, 0));
      drain();
      write_count(10'd0);
      send(make_req(stsel_pkg::OP_RECORD, 4, 0, 0, 0));
      send(make_req(stsel_pkg::OP_RECORD, 4, 0, 1, 0));
      send(make_req(stsel_pkg::OP_SELECT, 4, 0, 0, 0));
      drain();
      write_count(10'd100);
      random_phase(400);
      drain();
      send_idle = 72; recv_idle = 11;
      write_count(10'($urandom_range(1, 1023)));
      random_phase(400);
      drain();
      send_idle = 0; recv_idle = 0;
      write_count(10'd7);
      random_phase(200);
      drain();
      write_count(10'd1023);
      random_phase(200);
      drain();
      $display("sent %0d transfers over offspring counts 0, 1, 7, 100, 1023 and random;",
               n_sent);
      $display("checked %0d responses under three idling patterns", sb.results);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("symbiosis_transfer_selector_unit: match");
      else
         $display("symbiosis_transfer_selector_unit: mismatch");
      $finish;
   end
endmodule
